@@ rtl/core/ftpd_pkg.sv @@
// shared types and constants of the file transfer packet deframer
package ftpd_pkg;

  // register word indexes on the configuration port (byte address / 4)
  localparam logic [2:0] REG_DATA_CODE  = 3'd0;
  localparam logic [2:0] REG_START_CODE = 3'd1;
  localparam logic [2:0] REG_END_CODE   = 3'd2;
  localparam logic [2:0] REG_SIZE_TYPE  = 3'd3;
  localparam logic [2:0] REG_NAME_TYPE  = 3'd4;

  // packet status codes
  localparam logic [3:0] ST_DATA_OK  = 4'd0;
  localparam logic [3:0] ST_SEQ      = 4'd1;
  localparam logic [3:0] ST_LEN      = 4'd2;
  localparam logic [3:0] ST_START_OK = 4'd3;
  localparam logic [3:0] ST_END_OK   = 4'd4;
  localparam logic [3:0] ST_TOO_MANY = 4'd5;
  localparam logic [3:0] ST_ORDER    = 4'd6;
  localparam logic [3:0] ST_MISMATCH = 4'd7;
  localparam logic [3:0] ST_TOTAL    = 4'd8;
  localparam logic [3:0] ST_FORMAT   = 4'd9;

  // configuration seen by the parser
  typedef struct packed {
    logic [7:0] data_code;
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] size_type_code;
    logic [7:0] name_type_code;
  } cfg_t;

  // one result word
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        packet_done;
    logic [3:0]  packet_status;
    logic [31:0] announced_size;
    logic [31:0] bytes_received;
  } res_t;

endpackage

@@ rtl/core/ftpd_parser.sv @@
// byte parser: packet state, sequence and size checks, name store
module ftpd_parser #(
  parameter int unsigned NAME_DEPTH  = 256,
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  input  ftpd_pkg::cfg_t cfg_i,
  output ftpd_pkg::res_t res_o
);

  localparam int unsigned AW        = $clog2(NAME_DEPTH);
  localparam logic [15:0] MaxLen    = 16'(MAX_PAYLOAD);
  localparam logic [8:0]  NameDepth = 9'(NAME_DEPTH);

  // parse phases
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_SEQ     = 4'd1;
  localparam logic [3:0] PH_LEN_HI  = 4'd2;
  localparam logic [3:0] PH_LEN_LO  = 4'd3;
  localparam logic [3:0] PH_PAYLOAD = 4'd4;
  localparam logic [3:0] PH_TYPE    = 4'd5;
  localparam logic [3:0] PH_TLEN    = 4'd6;
  localparam logic [3:0] PH_VALUE   = 4'd7;
  localparam logic [3:0] PH_SKIP    = 4'd8;

  // packet kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  logic [3:0]  phase_q, phase_n, phase_d;
  logic [1:0]  kind_q, kind_n, kind_d;
  logic [3:0]  err_q, err_n, err_d;
  logic [7:0]  seq_q, seq_d;
  logic        start_seen_q, start_seen_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] total_q, total_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  ftype_q, ftype_d;
  logic [7:0]  name_len_q [2];
  logic [7:0]  name_len_d [2];
  logic [31:0] size_q [2];
  logic [31:0] size_d [2];
  logic        diff_q, diff_d;

  logic        done_a, fin, pvalid, done;
  logic [3:0]  status_a, fin_status, status;
  logic        wr_en;
  logic [7:0]  wr_idx;
  logic [7:0]  rd_idx;
  logic [7:0]  rd_q;
  logic [7:0]  name_mem_q [NAME_DEPTH];
  logic        slot_q, slot_d;

  assign slot_q = (kind_q == KIND_END);

  // one parser step on the current byte
  always_comb begin
    logic [3:0]  err_c;
    logic [1:0]  cnt_inc;
    logic [1:0]  kind_new;
    logic        slot_new;
    logic [15:0] len_tmp;
    logic [7:0]  idx;
    err_c    = ftpd_pkg::ST_DATA_OK;
    cnt_inc  = (cnt_q != 2'd3) ? cnt_q + 2'd1 : cnt_q;
    kind_new = start_seen_q ? KIND_END : KIND_START;
    slot_new = start_seen_q;
    len_tmp  = len_q - 16'd1;
    idx      = name_len_q[slot_q] - len_q[7:0];
    phase_n  = phase_q;
    kind_n   = kind_q;
    err_n    = err_q;
    seq_d    = seq_q;
    cnt_d    = cnt_q;
    total_d  = total_q;
    len_d    = len_q;
    ftype_d  = ftype_q;
    name_len_d[0] = name_len_q[0];
    name_len_d[1] = name_len_q[1];
    size_d[0] = size_q[0];
    size_d[1] = size_q[1];
    diff_d   = diff_q;
    done_a   = 1'b0;
    fin      = 1'b0;
    pvalid   = 1'b0;
    status_a = ftpd_pkg::ST_DATA_OK;
    wr_en    = 1'b0;
    wr_idx   = idx;
    unique case (phase_q)
      PH_IDLE: begin
        if (byte_i == cfg_i.data_code) begin
          kind_n  = KIND_DATA;
          phase_n = PH_SEQ;
          if (last_i) begin
            done_a   = 1'b1;
            status_a = ftpd_pkg::ST_FORMAT;
          end
        end else begin
          cnt_d  = cnt_inc;
          kind_n = kind_new;
          if (cnt_inc == 2'd3) begin
            err_c = ftpd_pkg::ST_TOO_MANY;
          end else if (!start_seen_q && byte_i != cfg_i.start_code) begin
            err_c = ftpd_pkg::ST_ORDER;
          end else if (start_seen_q && byte_i != cfg_i.end_code) begin
            err_c = ftpd_pkg::ST_ORDER;
          end
          if (err_c == ftpd_pkg::ST_DATA_OK) begin
            name_len_d[slot_new] = 8'd0;
            size_d[slot_new]     = 32'd0;
            diff_d  = 1'b0;
            phase_n = PH_TYPE;
            fin     = last_i;
          end
        end
      end
      PH_SEQ: begin
        if (byte_i != seq_q + 8'd1) begin
          err_c = ftpd_pkg::ST_SEQ;
        end else if (last_i) begin
          done_a   = 1'b1;
          status_a = ftpd_pkg::ST_FORMAT;
        end else begin
          phase_n = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_d = {byte_i, 8'h00};
        if (last_i) begin
          done_a   = 1'b1;
          status_a = ftpd_pkg::ST_FORMAT;
        end else begin
          phase_n = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        len_d = {len_q[15:8], byte_i};
        if (len_d > MaxLen) begin
          err_c = ftpd_pkg::ST_LEN;
        end else if (len_d == 16'd0) begin
          if (last_i) begin
            done_a   = 1'b1;
            status_a = ftpd_pkg::ST_DATA_OK;
            seq_d    = seq_q + 8'd1;
          end else begin
            err_c = ftpd_pkg::ST_LEN;
          end
        end else if (last_i) begin
          done_a   = 1'b1;
          status_a = ftpd_pkg::ST_LEN;
        end else begin
          phase_n = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pvalid = 1'b1;
        if (total_q != 32'hFFFF_FFFF) begin
          total_d = total_q + 32'd1;
        end
        len_d = len_tmp;
        if (len_tmp == 16'd0) begin
          if (last_i) begin
            done_a   = 1'b1;
            status_a = ftpd_pkg::ST_DATA_OK;
            seq_d    = seq_q + 8'd1;
          end else begin
            err_c = ftpd_pkg::ST_LEN;
          end
        end else if (last_i) begin
          done_a   = 1'b1;
          status_a = ftpd_pkg::ST_LEN;
        end
      end
      PH_TYPE: begin
        ftype_d = byte_i;
        if (last_i) begin
          done_a   = 1'b1;
          status_a = ftpd_pkg::ST_FORMAT;
        end else begin
          phase_n = PH_TLEN;
        end
      end
      PH_TLEN: begin
        len_d = {8'h00, byte_i};
        if (ftype_q == cfg_i.name_type_code) begin
          name_len_d[slot_q] = byte_i;
          diff_d = 1'b0;
        end else if (ftype_q == cfg_i.size_type_code) begin
          size_d[slot_q] = 32'd0;
        end
        if (byte_i == 8'd0) begin
          phase_n = PH_TYPE;
          fin     = last_i;
        end else begin
          phase_n = PH_VALUE;
          if (last_i) begin
            done_a   = 1'b1;
            status_a = ftpd_pkg::ST_FORMAT;
          end
        end
      end
      PH_VALUE: begin
        if (ftype_q == cfg_i.name_type_code) begin
          if ({1'b0, idx} < NameDepth) begin
            if (!slot_q) begin
              wr_en = step_i;
            end else if (idx < name_len_q[0] && rd_q != byte_i) begin
              diff_d = 1'b1;
            end
          end
        end else if (ftype_q == cfg_i.size_type_code) begin
          size_d[slot_q] = {size_q[slot_q][23:0], byte_i};
        end
        len_d = len_tmp;
        if (len_tmp == 16'd0) begin
          phase_n = PH_TYPE;
          fin     = last_i;
        end else if (last_i) begin
          done_a   = 1'b1;
          status_a = ftpd_pkg::ST_FORMAT;
        end
      end
      default: begin
        if (last_i) begin
          done_a = 1'b1;
          if (err_q != 4'd0 && err_q <= ftpd_pkg::ST_FORMAT) begin
            status_a = err_q;
          end else begin
            status_a = ftpd_pkg::ST_FORMAT;
          end
        end
      end
    endcase
    // a detected error skips the rest of the packet
    if (err_c != ftpd_pkg::ST_DATA_OK) begin
      err_n   = err_c;
      phase_n = PH_SKIP;
      if (last_i) begin
        done_a   = 1'b1;
        status_a = err_c;
      end
    end
  end

  // control packet verdict on the updated state
  always_comb begin
    if (kind_n == KIND_START) begin
      fin_status = ftpd_pkg::ST_START_OK;
    end else if (diff_d || name_len_d[0] != name_len_d[1] || size_d[0] != size_d[1]) begin
      fin_status = ftpd_pkg::ST_MISMATCH;
    end else if (total_d != size_d[0]) begin
      fin_status = ftpd_pkg::ST_TOTAL;
    end else begin
      fin_status = ftpd_pkg::ST_END_OK;
    end
  end

  assign done         = done_a | fin;
  assign status       = fin ? fin_status : status_a;
  assign start_seen_d = start_seen_q | (fin && kind_n == KIND_START);
  assign phase_d      = done ? PH_IDLE : phase_n;
  assign kind_d       = done ? KIND_NONE : kind_n;
  assign err_d        = done ? 4'd0 : err_n;
  assign slot_d       = (kind_d == KIND_END);

  // name store read address for the next value byte
  assign rd_idx = step_i ? (name_len_d[slot_d] - len_d[7:0])
                         : (name_len_q[slot_q] - len_q[7:0]);

  // name store, written by the start packet and read by the end packet
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      name_mem_q[wr_idx[AW-1:0]] <= byte_i;
    end
    rd_q <= name_mem_q[rd_idx[AW-1:0]];
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      kind_q        <= KIND_NONE;
      err_q         <= 4'd0;
      seq_q         <= 8'hFF;
      start_seen_q  <= 1'b0;
      cnt_q         <= 2'd0;
      total_q       <= 32'd0;
      len_q         <= 16'd0;
      ftype_q       <= 8'd0;
      name_len_q[0] <= 8'd0;
      name_len_q[1] <= 8'd0;
      size_q[0]     <= 32'd0;
      size_q[1]     <= 32'd0;
      diff_q        <= 1'b0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      kind_q        <= kind_d;
      err_q         <= err_d;
      seq_q         <= seq_d;
      start_seen_q  <= start_seen_d;
      cnt_q         <= cnt_d;
      total_q       <= total_d;
      len_q         <= len_d;
      ftype_q       <= ftype_d;
      name_len_q[0] <= name_len_d[0];
      name_len_q[1] <= name_len_d[1];
      size_q[0]     <= size_d[0];
      size_q[1]     <= size_d[1];
      diff_q        <= diff_d;
    end
  end

  // result of this step
  always_comb begin
    res_o.payload_valid  = pvalid;
    res_o.payload_byte   = pvalid ? byte_i : 8'd0;
    res_o.packet_done    = done;
    res_o.packet_status  = done ? status : ftpd_pkg::ST_DATA_OK;
    res_o.announced_size = size_d[0];
    res_o.bytes_received = total_d;
  end

  // state holds while no byte is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(total_q))
    else $error("parser state moved without a byte");

  // sequence advances only on a good data packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !(done && status == ftpd_pkg::ST_DATA_OK) |=> $stable(seq_q))
    else $error("sequence advanced without a good data packet");

  // start flag never clears outside reset
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(start_seen_q))
    else $error("start flag cleared");

  // payload total never decreases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> total_q >= $past(total_q))
    else $error("payload total decreased");

endmodule

@@ rtl/core/file_transfer_packet_deframer_unit.sv @@
// File transfer packet deframer, top level. Takes one packet byte per clock on the
// slave stream and returns one result word per byte on the master stream; a byte
// passes the input register, then the result register, and a new
// byte is taken every cycle while the result side keeps up. The single parser
// step between the two registers sets that rate; the file name store is a
// registered-read memory whose next address is prepared one byte ahead, so the
// end packet name comparison does not stall the stream. The user must write codes
// over the APB port only while no packet is in flight; the block does not enforce it.
module file_transfer_packet_deframer_unit #(
  parameter int unsigned NAME_DEPTH  = 256,
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  input  logic        s_axis_tlast,   // packet_last
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // payload_byte[7:0], packet_status[11:8], announced_size[43:12],
  // bytes_received[75:44], zero fill[79:76]
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tuser,   // payload_valid
  output logic        m_axis_tlast,   // packet_done
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ftpd_pkg::cfg_t cfg_q;
  ftpd_pkg::res_t res;
  ftpd_pkg::res_t out_q;
  logic           in_valid_q;
  logic [7:0]     in_byte_q;
  logic           in_last_q;
  logic           out_valid_q;
  logic           step;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_code      <= 8'd1;
      cfg_q.start_code     <= 8'd2;
      cfg_q.end_code       <= 8'd3;
      cfg_q.size_type_code <= 8'd0;
      cfg_q.name_type_code <= 8'd1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        ftpd_pkg::REG_DATA_CODE:  cfg_q.data_code      <= pwdata[7:0];
        ftpd_pkg::REG_START_CODE: cfg_q.start_code     <= pwdata[7:0];
        ftpd_pkg::REG_END_CODE:   cfg_q.end_code       <= pwdata[7:0];
        ftpd_pkg::REG_SIZE_TYPE:  cfg_q.size_type_code <= pwdata[7:0];
        ftpd_pkg::REG_NAME_TYPE:  cfg_q.name_type_code <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      ftpd_pkg::REG_DATA_CODE:  prdata = {24'd0, cfg_q.data_code};
      ftpd_pkg::REG_START_CODE: prdata = {24'd0, cfg_q.start_code};
      ftpd_pkg::REG_END_CODE:   prdata = {24'd0, cfg_q.end_code};
      ftpd_pkg::REG_SIZE_TYPE:  prdata = {24'd0, cfg_q.size_type_code};
      ftpd_pkg::REG_NAME_TYPE:  prdata = {24'd0, cfg_q.name_type_code};
      default:                  prdata = 32'd0;
    endcase
  end

  // a word moves from the input register when the result register is free
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= (s_axis_tvalid && s_axis_tready) || (in_valid_q && !step);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  ftpd_parser #(
    .NAME_DEPTH  (NAME_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.bytes_received, out_q.announced_size,
                          out_q.packet_status, out_q.payload_byte};
  assign m_axis_tuser  = out_q.payload_valid;
  assign m_axis_tlast  = out_q.packet_done;

endmodule
